[rtl/sacl_pkg.sv]
// Shared types and constants of the set-associative LRU cache store.
package sacl_pkg;

    localparam int unsigned SETS      = 64;
    localparam int unsigned WAYS      = 4;
    localparam int unsigned TAG_BITS  = 21;
    localparam int unsigned DATA_BITS = 64;
    localparam int unsigned SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int unsigned WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned LINES     = SETS * WAYS;
    localparam int unsigned QDEPTH    = 2;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_FILL  = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    typedef struct packed {
        logic [1:0]          mode;
        logic [SET_W-1:0]    set_idx;
        logic [TAG_BITS-1:0] tag;
        logic [63:0]         data;
    } t_req;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } t_state;

endpackage

[rtl/sacl_ram.sv]
// Generic RAM with one write port and one registered read port.
module sacl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/sacl_front.sv]
// Front end: accept commands and queue them for the back end.
module sacl_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [1:0]      i_mode,
    input  logic [5:0]      i_set_index,
    input  logic [20:0]     i_tag,
    input  logic [63:0]     i_write_data,
    output logic            o_full,
    output logic            o_q_valid,
    output sacl_pkg::t_req  o_q_req,
    input  logic            i_q_pop
);
    localparam int unsigned PW = $clog2(sacl_pkg::QDEPTH);

    sacl_pkg::t_req   r_q [sacl_pkg::QDEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [PW:0]      r_cnt;
    logic             push;
    sacl_pkg::t_req   req;

    always_comb begin
        req.mode    = i_mode;
        req.set_idx = sacl_pkg::SET_W'(i_set_index);
        req.tag     = sacl_pkg::TAG_BITS'(i_tag);
        req.data    = i_write_data;
    end

    assign o_full    = (r_cnt == (PW+1)'(sacl_pkg::QDEPTH));
    assign push      = i_start && !o_full;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_req   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (i_q_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(push) - (PW+1)'(i_q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= req;
    end
endmodule

[rtl/sacl_back.sv]
// Back end: read the set, compare ways, pick victim, update lines and ages.
module sacl_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  sacl_pkg::t_req  i_q_req,
    output logic            o_q_pop,
    output logic            o_done,
    output logic            o_hit,
    output logic [1:0]      o_way,
    output logic [63:0]     o_read_data,
    output logic            o_evict_valid,
    output logic            o_evict_dirty,
    output logic [20:0]     o_evict_tag,
    output logic [63:0]     o_evict_data
);
    localparam int unsigned W  = sacl_pkg::WAYS;
    localparam int unsigned WW = sacl_pkg::WAY_W;
    localparam int unsigned SW = sacl_pkg::SET_W;
    localparam int unsigned TB = sacl_pkg::TAG_BITS;
    localparam int unsigned DB = sacl_pkg::DATA_BITS;
    localparam int unsigned SD = sacl_pkg::SETS;
    // Per-set state word: valid bits, dirty bits, then one age rank per way.
    localparam int unsigned MW = 2 * W + W * WW;

    sacl_pkg::t_state r_state, n_state;
    sacl_pkg::t_req   r_req;
    logic [SW-1:0]    r_clr;

    logic [TB-1:0] tag_rd  [W];
    logic [DB-1:0] data_rd [W];
    logic          tag_we  [W];
    logic          data_we [W];
    logic          do_exec;
    logic          do_clear;

    logic [MW-1:0] meta_rd, meta_wd;
    logic [SW-1:0] meta_addr;
    logic          meta_we;

    logic [W-1:0]  vld, dty, match;
    logic [WW-1:0] age     [W];
    logic [WW-1:0] new_age [W];
    logic [W-1:0]  new_vld, new_dty;
    logic          found;
    logic [WW-1:0] fway, vway, sel;
    logic          any_inv;
    logic          upd;
    logic [WW-1:0] old_age;

    always_comb begin
        n_state = r_state;
        case (r_state)
            sacl_pkg::ST_CLEAR: if (r_clr == SW'(SD - 1)) n_state = sacl_pkg::ST_IDLE;
            sacl_pkg::ST_IDLE:  if (i_q_valid) n_state = sacl_pkg::ST_READ;
            sacl_pkg::ST_READ:  n_state = sacl_pkg::ST_EXEC;
            sacl_pkg::ST_EXEC:  n_state = sacl_pkg::ST_IDLE;
            default:            n_state = sacl_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop  = 1'b0;
        do_exec  = 1'b0;
        do_clear = 1'b0;
        case (r_state)
            sacl_pkg::ST_CLEAR: do_clear = 1'b1;
            sacl_pkg::ST_IDLE:  o_q_pop = i_q_valid;
            sacl_pkg::ST_EXEC:  do_exec = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sacl_pkg::ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (do_clear) r_clr <= r_clr + 1'b1;
        end
        if (o_q_pop) r_req <= i_q_req;
    end

    always_comb begin
        vld = meta_rd[W-1:0];
        dty = meta_rd[2*W-1:W];
        for (int w = 0; w < W; w++) age[w] = meta_rd[2*W + w*WW +: WW];
        found   = 1'b0;
        fway    = '0;
        any_inv = 1'b0;
        vway    = '0;
        for (int w = W - 1; w >= 0; w--) begin
            match[w] = vld[w] && (tag_rd[w] == r_req.tag);
            if (match[w]) begin
                found = 1'b1;
                fway  = WW'(w);
            end
            if (!vld[w]) begin
                any_inv = 1'b1;
                vway    = WW'(w);
            end
        end
        if (!any_inv) begin
            vway = '0;
            for (int w = 1; w < W; w++) begin
                if (age[w] > age[vway]) vway = WW'(w);
            end
        end
        sel = (r_req.mode == sacl_pkg::MODE_FILL) ? vway : fway;
        upd = (r_req.mode == sacl_pkg::MODE_FILL)
              || (found && (r_req.mode == sacl_pkg::MODE_READ
                            || r_req.mode == sacl_pkg::MODE_WRITE));
        old_age = age[sel];
        for (int w = 0; w < W; w++) begin
            tag_we[w]  = do_exec && (r_req.mode == sacl_pkg::MODE_FILL) && (sel == WW'(w));
            data_we[w] = do_exec && upd && (r_req.mode != sacl_pkg::MODE_READ)
                         && (sel == WW'(w));
            if (sel == WW'(w))
                new_age[w] = '0;
            else if (age[w] <= old_age && age[w] != WW'(W - 1))
                new_age[w] = age[w] + 1'b1;
            else
                new_age[w] = age[w];
        end
        new_vld = vld;
        new_dty = dty;
        if (r_req.mode == sacl_pkg::MODE_FILL) begin
            new_vld[sel] = 1'b1;
            new_dty[sel] = 1'b0;
        end else if (r_req.mode == sacl_pkg::MODE_WRITE) begin
            new_dty[sel] = 1'b1;
        end
        meta_wd = '0;
        if (!do_clear) begin
            meta_wd[W-1:0]   = new_vld;
            meta_wd[2*W-1:W] = new_dty;
            for (int w = 0; w < W; w++) meta_wd[2*W + w*WW +: WW] = new_age[w];
        end
        meta_we   = do_clear || (do_exec && upd);
        meta_addr = do_clear ? r_clr : r_req.set_idx;
    end

    // Valid, dirty and age of a whole set share one word; wipe it after reset.
    sacl_ram #(.WIDTH(MW), .DEPTH(SD)) u_meta (
        .i_clk(i_clk), .i_we(meta_we), .i_waddr(meta_addr),
        .i_wdata(meta_wd), .i_raddr(r_req.set_idx), .o_rdata(meta_rd));

    for (genvar g = 0; g < W; g++) begin : g_way
        sacl_ram #(.WIDTH(TB), .DEPTH(SD)) u_tag (
            .i_clk(i_clk), .i_we(tag_we[g]), .i_waddr(r_req.set_idx),
            .i_wdata(r_req.tag), .i_raddr(r_req.set_idx), .o_rdata(tag_rd[g]));
        sacl_ram #(.WIDTH(DB), .DEPTH(SD)) u_data (
            .i_clk(i_clk), .i_we(data_we[g]), .i_waddr(r_req.set_idx),
            .i_wdata(DB'(r_req.data)), .i_raddr(r_req.set_idx), .o_rdata(data_rd[g]));
    end

    always_comb begin
        o_done        = do_exec;
        o_hit         = do_exec && found && (r_req.mode != sacl_pkg::MODE_NONE);
        o_way         = '0;
        o_read_data   = '0;
        o_evict_valid = 1'b0;
        o_evict_dirty = 1'b0;
        o_evict_tag   = '0;
        o_evict_data  = '0;
        if (do_exec && upd) o_way = 2'(sel);
        if (do_exec && found && r_req.mode == sacl_pkg::MODE_READ)
            o_read_data = 64'(data_rd[fway]);
        if (do_exec && r_req.mode == sacl_pkg::MODE_FILL && vld[sel]) begin
            o_evict_valid = 1'b1;
            o_evict_dirty = dty[sel];
            o_evict_tag   = 21'(tag_rd[sel]);
            o_evict_data  = 64'(data_rd[sel]);
        end
    end
endmodule

[rtl/set_assoc_cache_lru.sv]
// Top level of the set-associative write-back cache store with LRU replacement.
//
//  channel  | signals                                          | direction
//  ---------+--------------------------------------------------+----------
//  command  | start/busy, i_mode, i_set_index, i_tag,          | in
//           | i_write_data                                     |
//  result   | o_valid, o_hit, o_way, o_read_data, o_evict_*    | out
//
// Each transfer passes through the back end as queue pop, tag/data/state RAM
// read (registered), then compare, victim pick and update. A new item is
// popped only after the last one is done. Unused mode 3 travels the same
// queue and is answered in order with all-zero fields.
// Reset is synchronous; the back end then wipes the valid, dirty and age
// word of every set, while commands may still queue up.
// The receiver cannot stall; busy rises only when the two-entry queue fills.
module set_assoc_cache_lru (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [5:0]  i_set_index,
    input  logic [20:0] i_tag,
    input  logic [63:0] i_write_data,
    output logic        o_valid,
    output logic        o_hit,
    output logic [1:0]  o_way,
    output logic [63:0] o_read_data,
    output logic        o_evict_valid,
    output logic        o_evict_dirty,
    output logic [20:0] o_evict_tag,
    output logic [63:0] o_evict_data
);
    logic           q_valid, q_pop, done;
    sacl_pkg::t_req q_req;

    // Front end: hold commands in a short queue.
    sacl_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_mode(i_mode), .i_set_index(i_set_index), .i_tag(i_tag),
        .i_write_data(i_write_data), .o_full(busy),
        .o_q_valid(q_valid), .o_q_req(q_req), .i_q_pop(q_pop));

    // Back end: carry out one queued transfer at a time.
    sacl_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid), .i_q_req(q_req),
        .o_q_pop(q_pop), .o_done(done), .o_hit(o_hit), .o_way(o_way),
        .o_read_data(o_read_data), .o_evict_valid(o_evict_valid),
        .o_evict_dirty(o_evict_dirty), .o_evict_tag(o_evict_tag),
        .o_evict_data(o_evict_data));

    // Every mode strobes once; the back end drives zeros when not done.
    assign o_valid = done;
endmodule

[rtl/sacl_checker.sv]
// Port-level checker for the cache store, bound to the top level.
module sacl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic        o_hit,
    input logic [1:0]  o_way,
    input logic [63:0] o_read_data,
    input logic        o_evict_valid,
    input logic        o_evict_dirty,
    input logic [20:0] o_evict_tag
);
    a_no_evict_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_evict_valid && !o_hit && o_way == '0)
        else $error("fields without strobe");
    a_dirty_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evict_dirty |-> o_evict_valid) else $error("dirty evict of invalid line");
    a_evict_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_evict_valid) |-> o_evict_tag == '0) else $error("stray evict tag");
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> o_read_data == '0) else $error("data on miss");
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !busy) else $error("activity after reset");
endmodule

bind set_assoc_cache_lru sacl_checker u_sacl_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_hit(o_hit), .o_way(o_way), .o_read_data(o_read_data),
    .o_evict_valid(o_evict_valid), .o_evict_dirty(o_evict_dirty),
    .o_evict_tag(o_evict_tag));
